/* design/bde_pkg.sv */
// bde_pkg: shared types, codes and sizes for the bounded deque engine
// used by bde_front, bde_back and bounded_deque_engine; no dependencies
package bde_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int DATA_W      = 32;
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int ENTRIES_W   = 6;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_BACK  = 3'd5,
        ACT_DUMP_FWD   = 3'd6,
        ACT_DUMP_BWD   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_PEEK = 2'd2,
        KIND_DUMP = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_DUMP = 1'b1
    } t_back_state;

    // classified request handed from the front to the back
    typedef struct packed {
        t_kind             kind;
        logic              at_back;
        logic [DATA_W-1:0] value;
    } t_cmd;

endpackage

/* design/bounded_deque_engine.sv */
// bounded_deque_engine: top level of the bounded double-ended queue
// depends on bde_pkg, bde_front and bde_back
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready tuser = action, tdata = value
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready tdata = data_out,status,entries;
//                                                    tlast = last
//
// push, pop and peek sustain one request per cycle while m_axis is ready; a result
// passes through the request queue, then the store read and result register
// a dump gives one result per entry, one per cycle while m_axis is ready, set by
// the single read port of the ring store; the 2-deep request queue keeps accepting
// until it fills, then o_s_axis_tready drops
// a stall on m_axis holds the result register and backs up into the request queue
// reset (synchronous, active low) empties the queue and the request queue; store
// contents are left as they were
module bounded_deque_engine #(
    parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request side
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [31:0]                  i_s_axis_tdata,  // [31:0] value
    input  logic [bde_pkg::ACTION_W-1:0] i_s_axis_tuser,  // [2:0] action
    // result side
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [39:0]                  o_m_axis_tdata,  // [31:0] data_out, [33:32] status,
                                                          // [39:34] entries
    output logic                         o_m_axis_tlast
);

    // classified request between front and back
    logic          cmd_valid;
    logic          cmd_ready;
    bde_pkg::t_cmd cmd;

    logic [bde_pkg::DATA_W-1:0]    data_out;
    logic [bde_pkg::STATUS_W-1:0]  status;
    logic [bde_pkg::ENTRIES_W-1:0] entries;

    bde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    bde_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_data_out  (data_out),
        .o_status    (status),
        .o_entries   (entries),
        .o_last      (o_m_axis_tlast)
    );

    // pack the result fields, data_out in the lowest bits and entries in the highest
    assign o_m_axis_tdata = {entries, status, data_out};

endmodule

/* design/bde_front.sv */
// bde_front: accepts requests, classifies the action and holds them in a short queue
// depends on bde_pkg
module bde_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_valid,
    output logic                         o_s_ready,
    input  logic [bde_pkg::ACTION_W-1:0] i_action,
    input  logic [bde_pkg::DATA_W-1:0]   i_value,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output bde_pkg::t_cmd                o_cmd
);

    bde_pkg::t_cmd                       r_q [bde_pkg::CMDQ_DEPTH];
    logic [bde_pkg::CMDQ_PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [bde_pkg::CMDQ_PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [bde_pkg::CMDQ_CNT_W-1:0]      r_cnt, n_cnt;
    bde_pkg::t_cmd                       dec_cmd;
    logic                                push, pop;

    // classify the action
    always_comb begin
        dec_cmd.value   = i_value;
        dec_cmd.at_back = 1'b0;
        dec_cmd.kind    = bde_pkg::KIND_PUSH;
        unique case (bde_pkg::t_action'(i_action))
            bde_pkg::ACT_PUSH_FRONT: begin
                dec_cmd.kind = bde_pkg::KIND_PUSH;
            end
            bde_pkg::ACT_PUSH_BACK: begin
                dec_cmd.kind    = bde_pkg::KIND_PUSH;
                dec_cmd.at_back = 1'b1;
            end
            bde_pkg::ACT_POP_FRONT: begin
                dec_cmd.kind = bde_pkg::KIND_POP;
            end
            bde_pkg::ACT_POP_BACK: begin
                dec_cmd.kind    = bde_pkg::KIND_POP;
                dec_cmd.at_back = 1'b1;
            end
            bde_pkg::ACT_PEEK_FRONT: begin
                dec_cmd.kind = bde_pkg::KIND_PEEK;
            end
            bde_pkg::ACT_PEEK_BACK: begin
                dec_cmd.kind    = bde_pkg::KIND_PEEK;
                dec_cmd.at_back = 1'b1;
            end
            bde_pkg::ACT_DUMP_FWD: begin
                dec_cmd.kind = bde_pkg::KIND_DUMP;
            end
            bde_pkg::ACT_DUMP_BWD: begin
                dec_cmd.kind    = bde_pkg::KIND_DUMP;
                dec_cmd.at_back = 1'b1;
            end
            default: begin
                dec_cmd.kind = bde_pkg::KIND_PUSH;
            end
        endcase
    end

    assign o_s_ready   = (r_cnt != bde_pkg::CMDQ_CNT_W'(bde_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_s_valid && o_s_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == bde_pkg::CMDQ_PTR_W'(bde_pkg::CMDQ_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == bde_pkg::CMDQ_PTR_W'(bde_pkg::CMDQ_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

/* design/bde_back.sv */
// bde_back: ring store, head/tail/count pointers, dump sequencer and result register
// depends on bde_pkg
module bde_back #(
    parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  bde_pkg::t_cmd                 i_cmd,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bde_pkg::DATA_W-1:0]    o_data_out,
    output logic [bde_pkg::STATUS_W-1:0]  o_status,
    output logic [bde_pkg::ENTRIES_W-1:0] o_entries,
    output logic                          o_last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] f_prev(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
    endfunction

    logic [bde_pkg::DATA_W-1:0] mem [DEPTH];
    logic [bde_pkg::DATA_W-1:0] r_rd_data;

    bde_pkg::t_back_state r_state, n_state;
    logic [IDX_W-1:0]     r_head, n_head;
    logic [IDX_W-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_dump_idx, n_dump_idx;
    logic [CNT_W-1:0]     r_dump_left, n_dump_left;
    logic                 r_dump_back, n_dump_back;

    logic                 r_out_valid;
    bde_pkg::t_status     r_out_status, n_out_status;
    logic [CNT_W-1:0]     r_out_count;
    logic                 r_out_last, n_out_last;
    logic                 r_out_use_mem, n_out_use_mem;

    logic                       out_free, out_load, cmd_fire;
    logic                       wr_en, rd_en;
    logic [IDX_W-1:0]           wr_addr, rd_addr, tail_prev;
    logic [bde_pkg::DATA_W-1:0] wr_data;
    logic                       is_full, is_empty;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cmd_ready = out_free && (r_state == bde_pkg::BK_IDLE);
    assign cmd_fire    = i_cmd_valid && o_cmd_ready;
    assign is_full     = (r_count == CNT_W'(DEPTH));
    assign is_empty    = (r_count == '0);
    assign tail_prev   = f_prev(r_tail);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bde_pkg::BK_IDLE: begin
                if (cmd_fire && i_cmd.kind == bde_pkg::KIND_DUMP &&
                    r_count > CNT_W'(1)) begin
                    n_state = bde_pkg::BK_DUMP;
                end
            end
            bde_pkg::BK_DUMP: begin
                if (out_free && r_dump_left == CNT_W'(1)) begin
                    n_state = bde_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = bde_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_dump_idx    = r_dump_idx;
        n_dump_left   = r_dump_left;
        n_dump_back   = r_dump_back;
        n_out_status  = bde_pkg::ST_OK;
        n_out_last    = 1'b1;
        n_out_use_mem = 1'b0;
        out_load      = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = r_tail;
        wr_data       = i_cmd.value;
        rd_en         = 1'b0;
        rd_addr       = r_head;
        unique case (r_state)
            bde_pkg::BK_IDLE: begin
                if (cmd_fire) begin
                    out_load = 1'b1;
                    if (i_cmd.kind == bde_pkg::KIND_PUSH) begin
                        if (is_full) begin
                            n_out_status = bde_pkg::ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                            if (i_cmd.at_back) begin
                                wr_addr = r_tail;
                                n_tail  = f_next(r_tail);
                            end else begin
                                wr_addr = f_prev(r_head);
                                n_head  = f_prev(r_head);
                            end
                        end
                    end else if (is_empty) begin
                        n_out_status = bde_pkg::ST_EMPTY;
                    end else begin
                        rd_en         = 1'b1;
                        n_out_use_mem = 1'b1;
                        rd_addr       = i_cmd.at_back ? tail_prev : r_head;
                        unique case (i_cmd.kind)
                            bde_pkg::KIND_POP: begin
                                n_count = r_count - 1'b1;
                                if (i_cmd.at_back) begin
                                    n_tail = tail_prev;
                                end else begin
                                    n_head = f_next(r_head);
                                end
                            end
                            bde_pkg::KIND_DUMP: begin
                                n_dump_back = i_cmd.at_back;
                                n_dump_left = r_count - 1'b1;
                                n_dump_idx  = i_cmd.at_back ? f_prev(tail_prev) :
                                              f_next(r_head);
                                n_out_last  = (r_count == CNT_W'(1));
                            end
                            default: begin
                                // peek leaves the pointers alone
                                n_count = r_count;
                            end
                        endcase
                    end
                end
            end
            bde_pkg::BK_DUMP: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    rd_en         = 1'b1;
                    rd_addr       = r_dump_idx;
                    n_out_use_mem = 1'b1;
                    n_out_last    = (r_dump_left == CNT_W'(1));
                    n_dump_left   = r_dump_left - 1'b1;
                    n_dump_idx    = r_dump_back ? f_prev(r_dump_idx) : f_next(r_dump_idx);
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bde_pkg::BK_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (out_free) begin
                r_out_valid <= out_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dump_idx  <= n_dump_idx;
        r_dump_left <= n_dump_left;
        r_dump_back <= n_dump_back;
        if (out_load) begin
            r_out_status  <= n_out_status;
            r_out_count   <= n_count;
            r_out_last    <= n_out_last;
            r_out_use_mem <= n_out_use_mem;
        end
    end

    // ring store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_use_mem ? r_rd_data : '0;
    assign o_status    = r_out_status;
    assign o_entries   = bde_pkg::ENTRIES_W'(r_out_count);
    assign o_last      = r_out_last;

endmodule

/* verif/bde_result_checker.sv */
`timescale 1ns / 1ps
// bde_result_checker: tracks the deque contents from accepted requests, predicts each
// result and compares it field by field with the result channel; depends on bde_pkg
module bde_result_checker #(
    parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] action
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] i_m_axis_tdata,   // [31:0] data_out, [33:32] status, [39:34] entries
    input  logic        i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_owed,
    output int          o_requests,
    output int          o_results,
    output int          o_dumps,
    output int          o_full_hits,
    output int          o_empty_hits
);

    localparam int SHOWN_MAX = 40;

    typedef struct {
        logic [31:0]      data;
        bde_pkg::t_status status;
        logic [5:0]       entries;
        logic             last;
    } deque_reply_t;

    // shadow copy of the ring store and its pointers
    logic [31:0]  ring [DEPTH];
    int           head_idx = 0;
    int           tail_idx = 0;
    int           held = 0;
    deque_reply_t owed_replies [$];

    int fail_total = 0;
    int requests_seen = 0;
    int results_seen = 0;
    int dumps_seen = 0;
    int full_seen = 0;
    int empty_seen = 0;

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        fail_total++;
        if (fail_total <= SHOWN_MAX)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic owe_reply(input logic [31:0] data, input bde_pkg::t_status status,
                             input logic last);
        deque_reply_t r;
        r.data    = data;
        r.status  = status;
        r.entries = held[5:0];
        r.last    = last;
        owed_replies.push_back(r);
    endtask

    task automatic apply_action(input bde_pkg::t_action act, input logic [31:0] val);
        int idx;
        if (act == bde_pkg::ACT_PUSH_FRONT || act == bde_pkg::ACT_PUSH_BACK) begin
            if (held >= DEPTH) begin
                full_seen++;
                owe_reply('0, bde_pkg::ST_FULL, 1'b1);
            end else begin
                if (act == bde_pkg::ACT_PUSH_FRONT) begin
                    head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    ring[head_idx] = val;
                end else begin
                    ring[tail_idx] = val;
                    tail_idx = (tail_idx + 1) % DEPTH;
                end
                held++;
                owe_reply('0, bde_pkg::ST_OK, 1'b1);
            end
        end else if (held == 0) begin
            empty_seen++;
            owe_reply('0, bde_pkg::ST_EMPTY, 1'b1);
        end else begin
            case (act)
                bde_pkg::ACT_POP_FRONT: begin
                    idx = head_idx;
                    head_idx = (head_idx + 1) % DEPTH;
                    held--;
                    owe_reply(ring[idx], bde_pkg::ST_OK, 1'b1);
                end
                bde_pkg::ACT_POP_BACK: begin
                    tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
                    held--;
                    owe_reply(ring[tail_idx], bde_pkg::ST_OK, 1'b1);
                end
                bde_pkg::ACT_PEEK_FRONT: owe_reply(ring[head_idx], bde_pkg::ST_OK, 1'b1);
                bde_pkg::ACT_PEEK_BACK:
                    owe_reply(ring[(tail_idx + DEPTH - 1) % DEPTH], bde_pkg::ST_OK, 1'b1);
                bde_pkg::ACT_DUMP_FWD: begin
                    dumps_seen++;
                    idx = head_idx;
                    for (int k = 0; k < held; k++) begin
                        owe_reply(ring[idx], bde_pkg::ST_OK, k == held - 1);
                        idx = (idx + 1) % DEPTH;
                    end
                end
                default: begin
                    dumps_seen++;
                    idx = (tail_idx + DEPTH - 1) % DEPTH;
                    for (int k = 0; k < held; k++) begin
                        owe_reply(ring[idx], bde_pkg::ST_OK, k == held - 1);
                        idx = (idx + DEPTH - 1) % DEPTH;
                    end
                end
            endcase
        end
    endtask

    task automatic check_result();
        deque_reply_t want;
        if (owed_replies.size() == 0) begin
            report_mismatch("result with nothing outstanding", i_m_axis_tdata, '0);
            return;
        end
        want = owed_replies.pop_front();
        if (i_m_axis_tdata[31:0] !== want.data)
            report_mismatch("data_out", 40'(i_m_axis_tdata[31:0]), 40'(want.data));
        if (i_m_axis_tdata[33:32] !== 2'(want.status))
            report_mismatch("status", 40'(i_m_axis_tdata[33:32]), 40'(2'(want.status)));
        if (i_m_axis_tdata[39:34] !== want.entries)
            report_mismatch("entries", 40'(i_m_axis_tdata[39:34]), 40'(want.entries));
        if (i_m_axis_tlast !== want.last)
            report_mismatch("last", 40'(i_m_axis_tlast), 40'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            // store contents survive reset; the pointers and the owed results clear
            head_idx = 0;
            tail_idx = 0;
            held = 0;
            owed_replies.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                requests_seen++;
                apply_action(bde_pkg::t_action'(i_s_axis_tuser), i_s_axis_tdata);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                check_result();
            end
        end
        // exported after the edge so readers at the edge see settled values
        o_fail_count <= fail_total;
        o_owed       <= owed_replies.size();
        o_requests   <= requests_seen;
        o_results    <= results_seen;
        o_dumps      <= dumps_seen;
        o_full_hits  <= full_seen;
        o_empty_hits <= empty_seen;
    end

endmodule

/* verif/bounded_deque_engine_test.sv */
`timescale 1ns / 1ps
// bounded_deque_engine_test: drives requests into the deque engine under random stalls
// and gives the verdict; depends on bde_pkg, bounded_deque_engine and bde_result_checker
module bounded_deque_engine_test;

    localparam int DEPTH         = bde_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 470;
    localparam int QUIET_ITEMS   = 60;   // tail of the run with no idling on either side
    localparam int SETTLE_CYCLES = 20;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [31:0]               i_s_axis_tdata;   // [31:0] value
    logic [2:0]                i_s_axis_tuser;   // [2:0] action
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    logic [39:0]               o_m_axis_tdata;   // [31:0] data_out, [33:32] status,
                                                 // [39:34] entries
    logic                      o_m_axis_tlast;

    int fail_count;
    int owed_count;
    int request_count;
    int result_count;
    int dump_count;
    int full_hits;
    int empty_hits;
    int cycle_count = 0;
    bit quiet = 1'b0;

    bounded_deque_engine #(.DEPTH(DEPTH)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    bde_result_checker #(.DEPTH(DEPTH)) result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_owed          (owed_count),
        .o_requests      (request_count),
        .o_results       (result_count),
        .o_dumps         (dump_count),
        .o_full_hits     (full_hits),
        .o_empty_hits    (empty_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, owed_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: ready runs of random length broken by stall bursts, none once quiet
    initial begin
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 3) != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
        end
    end

    // hold one request until accepted, then maybe leave a gap
    task automatic send_request(input bde_pkg::t_action act, input logic [31:0] val);
        i_s_axis_tuser  <= act;
        i_s_axis_tdata  <= val;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // hold off new requests until every owed result has come back
    task automatic wait_until_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (owed_count != 0);
    endtask

    // data words lean on the signed extremes now and then
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic bde_pkg::t_action pick_action(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? bde_pkg::ACT_PUSH_BACK : bde_pkg::ACT_PUSH_FRONT;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? bde_pkg::ACT_POP_BACK : bde_pkg::ACT_POP_FRONT;
        case ($urandom_range(0, 3))
            0:       return bde_pkg::ACT_PEEK_FRONT;
            1:       return bde_pkg::ACT_PEEK_BACK;
            2:       return bde_pkg::ACT_DUMP_FWD;
            default: return bde_pkg::ACT_DUMP_BWD;
        endcase
    endfunction

    // one phase of random requests with a given push / pop mix
    task automatic run_phase(input int n, input int push_pct, input int pop_pct,
                             inout int sent);
        for (int k = 0; k < n && sent < RANDOM_ITEMS; k++) begin
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            send_request(pick_action(push_pct, pop_pct), pick_value());
            sent++;
        end
    endtask

    initial begin
        int sent;
        int phase;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= bde_pkg::ACT_PUSH_FRONT;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every read-type action on the empty queue
        send_request(bde_pkg::ACT_POP_FRONT,  $urandom());
        send_request(bde_pkg::ACT_POP_BACK,   $urandom());
        send_request(bde_pkg::ACT_PEEK_FRONT, $urandom());
        send_request(bde_pkg::ACT_PEEK_BACK,  $urandom());
        send_request(bde_pkg::ACT_DUMP_FWD,   $urandom());
        send_request(bde_pkg::ACT_DUMP_BWD,   $urandom());
        // removing the only entry, from either end
        send_request(bde_pkg::ACT_PUSH_BACK,  32'h7FFF_FFFF);
        send_request(bde_pkg::ACT_POP_FRONT,  $urandom());
        send_request(bde_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        send_request(bde_pkg::ACT_POP_BACK,   $urandom());
        send_request(bde_pkg::ACT_PEEK_BACK,  $urandom());
        // extremes at both ends, wrapping the head below slot zero
        send_request(bde_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(bde_pkg::ACT_PUSH_BACK,  32'h0000_0000);
        send_request(bde_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        send_request(bde_pkg::ACT_PUSH_BACK,  32'h7FFF_FFFF);
        send_request(bde_pkg::ACT_PUSH_FRONT, 32'h5555_5555);
        send_request(bde_pkg::ACT_PUSH_BACK,  32'hAAAA_AAAA);
        send_request(bde_pkg::ACT_PEEK_FRONT, $urandom());
        send_request(bde_pkg::ACT_PEEK_BACK,  $urandom());
        send_request(bde_pkg::ACT_DUMP_FWD,   $urandom());
        send_request(bde_pkg::ACT_DUMP_BWD,   $urandom());
        send_request(bde_pkg::ACT_POP_FRONT,  $urandom());
        send_request(bde_pkg::ACT_POP_BACK,   $urandom());
        wait_until_drained();

        // random part: fill to overflow, mix, drain past empty, mix again
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase % 4)
                0:       run_phase(48, 90, 3, sent);
                1:       run_phase(40, 35, 35, sent);
                2:       run_phase(48, 5, 85, sent);
                default: run_phase(40, 45, 25, sent);
            endcase
            if (!quiet && $urandom_range(0, 2) == 0)
                wait_until_drained();
            phase++;
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d results, %0d of them from %0d dumps",
                 request_count, result_count, result_count - request_count + dump_count,
                 dump_count);
        $display("refused %0d pushes on a full queue and %0d reads on an empty one",
                 full_hits, empty_hits);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
